FILE: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define GTC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// Next-cycle implication, switched off while reset is held.
`define GTC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

FILE: hw/rtl/gtc_pkg.sv
`default_nettype none

package gtc_pkg;

	localparam int unsigned STAGES = 21;

	localparam int unsigned MS_PER_SEC       = 1000;
	localparam int unsigned SECS_PER_DAY     = 86400;
	localparam int unsigned SECS_PER_HOUR    = 3600;
	localparam int unsigned SECS_PER_MIN     = 60;
	localparam int unsigned DAYS_GPS_TO_1970 = 3657;
	localparam int unsigned DAYS_0000_TO_1970 = 719468;
	localparam int unsigned DAYS_PER_ERA     = 146097;
	localparam int unsigned DAYS_PER_4Y      = 1460;
	localparam int unsigned DAYS_PER_100Y    = 36524;
	localparam int unsigned DAYS_PER_ERA_M1  = 146096;
	localparam int unsigned DAYS_PER_YEAR    = 365;
	localparam int unsigned DAYS_PER_5MONTH  = 153;
	localparam int unsigned MONTH_SPAN_DIV   = 5;
	localparam int unsigned YEARS_PER_CENT   = 100;
	localparam int unsigned YEARS_PER_ERA    = 400;

	localparam logic [20:0] DAY_BASE = 21'(DAYS_GPS_TO_1970 + DAYS_0000_TO_1970);

	typedef struct packed {
		logic [15:0] week_number;
		logic [29:0] time_of_week_ms;
	} gtc_gps_t;

	typedef struct packed {
		logic [4:0]  day_of_month;
		logic [3:0]  month_number;
		logic [11:0] full_year;
		logic [6:0]  year_two_digit;
		logic [4:0]  hour_of_day;
		logic [5:0]  minute_of_hour;
		logic [5:0]  second_of_minute;
	} gtc_date_t;

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} gtc_tod_t;

	typedef struct packed {
		logic [STAGES:1] en;
		logic [STAGES:1] vld;
	} gtc_pipe_t;

endpackage

`default_nettype wire

FILE: hw/rtl/gtc_cdiv.sv
`default_nettype none

module gtc_cdiv #(
	parameter int unsigned W  = 18,
	parameter int unsigned D  = 365,
	parameter int unsigned QW = 9,
	parameter int unsigned RW = 9
) (
	input  wire logic          clk,
	input  wire logic          en_a,
	input  wire logic          en_b,
	input  wire logic [W-1:0]  x,
	output logic      [QW-1:0] q,
	output logic      [RW-1:0] r
);

	// The reciprocal is rounded down, so the first estimate is exact or one short.
	localparam longint unsigned RECIP = (64'd1 << W) / D;
	localparam logic [W-1:0] RECIP_K = W'(RECIP);
	localparam logic [W-1:0] DIV_K   = W'(D);

	logic [2*W-1:0] prod;
	logic [W-1:0]   x_s1;
	logic [W-1:0]   qe_s1;
	logic [W-1:0]   back;
	logic [W-1:0]   diff;
	logic           fix;
	logic [QW-1:0]  q_s2;
	logic [RW-1:0]  r_s2;

	assign prod = (2*W)'(x) * (2*W)'(RECIP_K);

	always_ff @(posedge clk) begin
		if (en_a) begin
			x_s1  <= x;
			qe_s1 <= prod[2*W-1:W];
		end
	end

	assign back = qe_s1 * DIV_K;
	assign diff = x_s1 - back;
	assign fix  = (diff >= DIV_K);

	always_ff @(posedge clk) begin
		if (en_b) begin
			q_s2 <= QW'(qe_s1 + W'(fix));
			r_s2 <= RW'(fix ? diff - DIV_K : diff);
		end
	end

	assign q = q_s2;
	assign r = r_s2;

endmodule

`default_nettype wire

FILE: hw/rtl/gtc_pipe_ctrl.sv
`default_nettype none
`include "assert_macros.svh"

module gtc_pipe_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output gtc_pkg::gtc_pipe_t     pipe
);

	import gtc_pkg::*;

	logic [STAGES:1] vld_q;
	logic [STAGES:1] en;
	logic            in_acc;
	logic            out_acc;
	int unsigned     occ;

	// A stage may load when it or any stage after it is empty, or the output is taken.
	always_comb begin
		for (int k = 1; k <= STAGES; k++) begin
			en[k] = out_ready || ((vld_q | STAGES'((64'd1 << (k - 1)) - 64'd1)) != '1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) vld_q[1] <= in_valid;
			for (int k = 2; k <= STAGES; k++) begin
				if (en[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign in_ready  = en[1];
	assign out_valid = vld_q[STAGES];
	assign pipe.en   = en;
	assign pipe.vld  = vld_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;
	assign occ     = $countones(vld_q);

	`GTC_ASSERT_IMP(a_ready_when_room, clk, arst_n, vld_q != '1, in_ready)
	`GTC_ASSERT_NXT(a_no_loss, clk, arst_n, 1'b1, occ + $past(out_acc) == $past(occ) + $past(in_acc))

endmodule

`default_nettype wire

FILE: hw/rtl/gps_time_to_calendar_date_core.sv
// GPS week and time of week to calendar date and time of day.
//
// Input channel gps_valid / gps_ready / gps_time carries a week number and a
// time of week in milliseconds; output channel date_valid / date_ready /
// date_time returns one date and time of day per input transaction, in order.
// Milliseconds are truncated to whole seconds and no leap seconds are applied.
//
// The work is split into 21 register stages of constant-divisor units
// (reciprocal multiply, then one correction step). A new transaction is taken
// every cycle unless every stage is full and date_ready is low; throughput is
// then one per clock.
//
// When date_ready is low the finished result holds on date_time; stages
// behind it keep moving until they close up, and gps_ready falls only when
// every stage holds a transaction. Reset clears all stage valid bits, so
// nothing is presented after reset until a transaction has passed through.
`default_nettype none
`include "assert_macros.svh"

module gps_time_to_calendar_date_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                gps_valid,
	output logic                     gps_ready,
	input  wire gtc_pkg::gtc_gps_t   gps_time,
	output logic                     date_valid,
	input  wire logic                date_ready,
	output gtc_pkg::gtc_date_t       date_time
);

	import gtc_pkg::*;

	gtc_pipe_t   pipe;
	logic [STAGES:1] en;

	logic [15:0] week_s1;
	logic [18:0] week7_s2, week7_s3, week7_s4;
	logic [20:0] tow_sec_s2;
	logic [3:0]  dt_s4;
	logic [16:0] sod_s4;
	logic [20:0] days_s5;
	logic [4:0]  hour_s6, hour_s7, hour_s8;
	logic [11:0] hrem_s6;
	logic [5:0]  minute_s8, second_s8;
	gtc_tod_t    tod_s [9:20];
	logic [3:0]  era_s7;
	logic [17:0] doe_s7;
	logic [3:0]  era_s [8:12];
	logic [17:0] doe_s [8:13];
	logic [6:0]  c4y_s9;
	logic [2:0]  c100y_s9;
	logic [0:0]  cera_s9;
	logic [17:0] t_s10;
	logic [8:0]  yoe_s12;
	logic [1:0]  cent;
	logic [17:0] dec_s13;
	logic [11:0] ybase_s13;
	logic [11:0] ybase_s [14:17];
	logic [8:0]  doy_s14;
	logic [8:0]  doy_s [15:20];
	logic [10:0] v_s15;
	logic [3:0]  mp_s17;
	logic [10:0] w_s18;
	logic [3:0]  month_s18, month_s19, month_s20;
	logic [11:0] year_s18, year_s19, year_s20;
	logic [8:0]  wq_s20;
	logic [6:0]  ymod_s20;
	gtc_date_t   res_s21;
	logic        date_ok;
	logic        tod_ok;

	gtc_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (gps_valid),
		.in_ready  (gps_ready),
		.out_valid (date_valid),
		.out_ready (date_ready),
		.pipe      (pipe)
	);

	assign en = pipe.en;

	// Seconds within the week and the week count in days.
	gtc_cdiv #(.W(30), .D(MS_PER_SEC), .QW(21), .RW(10)) u_div_ms (
		.clk (clk), .en_a (en[1]), .en_b (en[2]),
		.x (gps_time.time_of_week_ms), .q (tow_sec_s2), .r ()
	);

	always_ff @(posedge clk) begin
		if (en[1]) week_s1  <= gps_time.week_number;
		if (en[2]) week7_s2 <= (19'(week_s1) << 3) - 19'(week_s1);
		if (en[3]) week7_s3 <= week7_s2;
		if (en[4]) week7_s4 <= week7_s3;
	end

	// A whole week is a whole number of days, so the second of the day
	// comes from the time of week alone.
	gtc_cdiv #(.W(21), .D(SECS_PER_DAY), .QW(4), .RW(17)) u_div_day (
		.clk (clk), .en_a (en[3]), .en_b (en[4]),
		.x (tow_sec_s2), .q (dt_s4), .r (sod_s4)
	);

	always_ff @(posedge clk) begin
		if (en[5]) days_s5 <= 21'(week7_s4) + 21'(dt_s4) + DAY_BASE;
	end

	// Time of day.
	gtc_cdiv #(.W(17), .D(SECS_PER_HOUR), .QW(5), .RW(12)) u_div_hour (
		.clk (clk), .en_a (en[5]), .en_b (en[6]),
		.x (sod_s4), .q (hour_s6), .r (hrem_s6)
	);

	gtc_cdiv #(.W(12), .D(SECS_PER_MIN), .QW(6), .RW(6)) u_div_min (
		.clk (clk), .en_a (en[7]), .en_b (en[8]),
		.x (hrem_s6), .q (minute_s8), .r (second_s8)
	);

	always_ff @(posedge clk) begin
		if (en[7]) hour_s7 <= hour_s6;
		if (en[8]) hour_s8 <= hour_s7;
		if (en[9]) tod_s[9] <= '{hour: hour_s8, minute: minute_s8, second: second_s8};
		for (int k = 10; k <= 20; k++) begin
			if (en[k]) tod_s[k] <= tod_s[k-1];
		end
	end

	// Era and day of era, counted from a year that starts in March.
	gtc_cdiv #(.W(21), .D(DAYS_PER_ERA), .QW(4), .RW(18)) u_div_era (
		.clk (clk), .en_a (en[6]), .en_b (en[7]),
		.x (days_s5), .q (era_s7), .r (doe_s7)
	);

	gtc_cdiv #(.W(18), .D(DAYS_PER_4Y), .QW(7), .RW(11)) u_div_4y (
		.clk (clk), .en_a (en[8]), .en_b (en[9]),
		.x (doe_s7), .q (c4y_s9), .r ()
	);

	gtc_cdiv #(.W(18), .D(DAYS_PER_100Y), .QW(3), .RW(16)) u_div_100y (
		.clk (clk), .en_a (en[8]), .en_b (en[9]),
		.x (doe_s7), .q (c100y_s9), .r ()
	);

	gtc_cdiv #(.W(18), .D(DAYS_PER_ERA_M1), .QW(1), .RW(18)) u_div_lastday (
		.clk (clk), .en_a (en[8]), .en_b (en[9]),
		.x (doe_s7), .q (cera_s9), .r ()
	);

	always_ff @(posedge clk) begin
		if (en[8]) era_s[8] <= era_s7;
		for (int k = 9; k <= 12; k++) begin
			if (en[k]) era_s[k] <= era_s[k-1];
		end
		if (en[8]) doe_s[8] <= doe_s7;
		for (int k = 9; k <= 13; k++) begin
			if (en[k]) doe_s[k] <= doe_s[k-1];
		end
		if (en[10]) t_s10 <= doe_s[9] - 18'(c4y_s9) + 18'(c100y_s9) - 18'(cera_s9);
	end

	gtc_cdiv #(.W(18), .D(DAYS_PER_YEAR), .QW(9), .RW(9)) u_div_year (
		.clk (clk), .en_a (en[11]), .en_b (en[12]),
		.x (t_s10), .q (yoe_s12), .r ()
	);

	// The year of the era stays below 400, so its century is a short compare.
	always_comb begin
		if (yoe_s12 >= 9'd300)      cent = 2'd3;
		else if (yoe_s12 >= 9'd200) cent = 2'd2;
		else if (yoe_s12 >= 9'd100) cent = 2'd1;
		else                        cent = 2'd0;
	end

	always_ff @(posedge clk) begin
		if (en[13]) begin
			dec_s13   <= 18'(yoe_s12) * 18'(DAYS_PER_YEAR) + 18'(yoe_s12[8:2]) - 18'(cent);
			ybase_s13 <= 12'(era_s[12]) * 12'(YEARS_PER_ERA) + 12'(yoe_s12);
		end
		if (en[14]) begin
			doy_s14     <= 9'(doe_s[13] - dec_s13);
			ybase_s[14] <= ybase_s13;
		end
		for (int k = 15; k <= 17; k++) begin
			if (en[k]) ybase_s[k] <= ybase_s[k-1];
		end
		if (en[15]) begin
			v_s15     <= 11'(doy_s14) * 11'd5 + 11'd2;
			doy_s[15] <= doy_s14;
		end
		for (int k = 16; k <= 20; k++) begin
			if (en[k]) doy_s[k] <= doy_s[k-1];
		end
	end

	gtc_cdiv #(.W(11), .D(DAYS_PER_5MONTH), .QW(4), .RW(8)) u_div_month (
		.clk (clk), .en_a (en[16]), .en_b (en[17]),
		.x (v_s15), .q (mp_s17), .r ()
	);

	// January and February belong to the following civil year.
	always_ff @(posedge clk) begin
		if (en[18]) begin
			w_s18     <= 11'(mp_s17) * 11'(DAYS_PER_5MONTH) + 11'd2;
			month_s18 <= (mp_s17 < 4'd10) ? mp_s17 + 4'd3 : mp_s17 - 4'd9;
			year_s18  <= ybase_s[17] + 12'(mp_s17 >= 4'd10);
		end
		if (en[19]) begin
			month_s19 <= month_s18;
			year_s19  <= year_s18;
		end
		if (en[20]) begin
			month_s20 <= month_s19;
			year_s20  <= year_s19;
		end
	end

	gtc_cdiv #(.W(11), .D(MONTH_SPAN_DIV), .QW(9), .RW(3)) u_div_mstart (
		.clk (clk), .en_a (en[19]), .en_b (en[20]),
		.x (w_s18), .q (wq_s20), .r ()
	);

	gtc_cdiv #(.W(12), .D(YEARS_PER_CENT), .QW(6), .RW(7)) u_div_yy (
		.clk (clk), .en_a (en[19]), .en_b (en[20]),
		.x (year_s18), .q (), .r (ymod_s20)
	);

	always_ff @(posedge clk) begin
		if (en[21]) begin
			res_s21.day_of_month     <= 5'(doy_s[20] - wq_s20 + 9'd1);
			res_s21.month_number     <= month_s20;
			res_s21.full_year        <= year_s20;
			res_s21.year_two_digit   <= ymod_s20;
			res_s21.hour_of_day      <= tod_s[20].hour;
			res_s21.minute_of_hour   <= tod_s[20].minute;
			res_s21.second_of_minute <= tod_s[20].second;
		end
	end

	assign date_time = res_s21;

	assign date_ok = date_time.day_of_month != 5'd0 && date_time.month_number != 4'd0
		&& date_time.month_number <= 4'd12 && date_time.year_two_digit <= 7'd99;
	assign tod_ok  = date_time.hour_of_day <= 5'd23 && date_time.minute_of_hour <= 6'd59
		&& date_time.second_of_minute <= 6'd59;

	`GTC_ASSERT_IMP(a_date_range, clk, arst_n, date_valid, date_ok)
	`GTC_ASSERT_IMP(a_tod_range, clk, arst_n, date_valid, tod_ok)

endmodule

`default_nettype wire

FILE: verif/gps_time_to_calendar_date_core_test.sv
`timescale 1ns / 1ps

module gps_time_to_calendar_date_core_test;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int unsigned MAX_TOW_IN_WEEK = 604799999;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic gps_valid = 1'b0;
	logic gps_ready;
	gtc_pkg::gtc_gps_t gps_time = '0;
	logic date_valid;
	logic date_ready = 1'b0;
	gtc_pkg::gtc_date_t date_time;

	gtc_pkg::gtc_date_t expected_dates[$];
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	bit source_idles = 1'b0;
	bit sink_stalls = 1'b0;

	gps_time_to_calendar_date_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.gps_valid  (gps_valid),
		.gps_ready  (gps_ready),
		.gps_time   (gps_time),
		.date_valid (date_valid),
		.date_ready (date_ready),
		.date_time  (date_time)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Civil date from days since 0000-03-01, using 400-year eras that start in March.
	function automatic gtc_pkg::gtc_date_t calendar_from_gps(gtc_pkg::gtc_gps_t t);
		gtc_pkg::gtc_date_t r;
		longint unsigned secs, days, era, doe, yoe, year, doy, mp, day, month, sod;
		secs = longint'(t.week_number) * 604800 + longint'(t.time_of_week_ms) / 1000;
		days = secs / 86400 + 3657 + 719468;
		era = days / 146097;
		doe = days - era * 146097;
		yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
		year = yoe + era * 400;
		doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
		mp = (5 * doy + 2) / 153;
		day = doy - (153 * mp + 2) / 5 + 1;
		month = (mp < 10) ? mp + 3 : mp - 9;
		if (month <= 2) begin
			year = year + 1;
		end
		sod = secs % 86400;
		r.day_of_month = 5'(day);
		r.month_number = 4'(month);
		r.full_year = 12'(year);
		r.year_two_digit = 7'(year % 100);
		r.hour_of_day = 5'(sod / 3600);
		r.minute_of_hour = 6'((sod % 3600) / 60);
		r.second_of_minute = 6'(sod % 60);
		return r;
	endfunction

	// Mostly short pauses, now and then a long one.
	function automatic int unsigned idle_length();
		if ($urandom_range(0, 9) < 8) begin
			return $urandom_range(0, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	function automatic gtc_pkg::gtc_gps_t random_gps();
		gtc_pkg::gtc_gps_t t;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		t.week_number = 16'($urandom);
		if (pick < 70) begin
			t.time_of_week_ms = 30'($urandom_range(0, MAX_TOW_IN_WEEK));
		end else if (pick < 90) begin
			t.time_of_week_ms = 30'($urandom);
		end else begin
			t.week_number = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			t.time_of_week_ms = $urandom_range(0, 1) ? 30'(MAX_TOW_IN_WEEK) : 30'h3FFF_FFFF;
		end
		return t;
	endfunction

	// Entered and left at a falling edge; valid stays high into the next transaction
	// unless a gap is chosen.
	task automatic send_gps(input gtc_pkg::gtc_gps_t t);
		int unsigned gap;
		gap = source_idles ? idle_length() : 0;
		if (gap > 0) begin
			gps_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		gps_valid <= 1'b1;
		gps_time <= t;
		do begin
			@(posedge clk);
		end while (!gps_ready);
		expected_dates.push_back(calendar_from_gps(t));
		@(negedge clk);
	endtask

	task automatic send_gps_day(input int unsigned gps_day, input int unsigned day_secs,
			input int unsigned ms);
		gtc_pkg::gtc_gps_t t;
		longint unsigned total;
		total = longint'(gps_day) * 86400 + day_secs;
		t.week_number = 16'(total / 604800);
		t.time_of_week_ms = 30'((total % 604800) * 1000 + ms);
		send_gps(t);
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endtask

	initial begin
		gtc_pkg::gtc_date_t want;
		forever begin
			@(posedge clk);
			if (arst_n && date_valid && date_ready) begin
				if (expected_dates.size() == 0) begin
					$error("date transaction with nothing outstanding");
					mismatch_count++;
				end else begin
					want = expected_dates.pop_front();
					compare_field("day_of_month", want.day_of_month, date_time.day_of_month);
					compare_field("month_number", want.month_number, date_time.month_number);
					compare_field("full_year", want.full_year, date_time.full_year);
					compare_field("year_two_digit", want.year_two_digit,
						date_time.year_two_digit);
					compare_field("hour_of_day", want.hour_of_day, date_time.hour_of_day);
					compare_field("minute_of_hour", want.minute_of_hour,
						date_time.minute_of_hour);
					compare_field("second_of_minute", want.second_of_minute,
						date_time.second_of_minute);
				end
			end
		end
	end

	initial begin
		int unsigned on_len, off_len;
		forever begin
			off_len = sink_stalls ? idle_length() : 0;
			on_len = sink_stalls ? $urandom_range(1, 8) : 1;
			if (off_len > 0) begin
				date_ready <= 1'b0;
				repeat (off_len) @(negedge clk);
			end
			date_ready <= 1'b1;
			repeat (on_len) @(negedge clk);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	task automatic test_calendar_edges();
		source_idles = 1'b0;
		sink_stalls = 1'b0;
		send_gps('{week_number: 16'd0, time_of_week_ms: 30'd0});
		send_gps('{week_number: 16'd0, time_of_week_ms: 30'd999});
		send_gps('{week_number: 16'd0, time_of_week_ms: 30'(MAX_TOW_IN_WEEK)});
		send_gps('{week_number: 16'hFFFF, time_of_week_ms: 30'h3FFF_FFFF});
		send_gps('{week_number: 16'hFFFF, time_of_week_ms: 30'd0});
		// A time of week beyond one week carries into the following days.
		send_gps('{week_number: 16'd0, time_of_week_ms: 30'h3FFF_FFFF});
		send_gps('{week_number: 16'h5555, time_of_week_ms: 30'h2AAA_AAAA});
		send_gps('{week_number: 16'hAAAA, time_of_week_ms: 30'h1555_5555});
		send_gps('{week_number: 16'h8000, time_of_week_ms: 30'h2000_0000});
		// End of the first GPS year and the turn into 1981.
		send_gps_day(360, 43200, 500);
		send_gps_day(361, 0, 0);
		// Turn of the millennium and the century leap day of 2000.
		send_gps_day(7299, 86399, 999);
		send_gps_day(7300, 0, 0);
		send_gps_day(7358, 3599, 0);
		send_gps_day(7359, 86399, 0);
		send_gps_day(7360, 0, 1);
		// 2100 is not a leap year.
		send_gps_day(43883, 86399, 999);
		send_gps_day(43884, 0, 0);
		// The leap day of 2400 is the last day of a 400-year era.
		send_gps_day(153456, 59, 0);
		send_gps_day(153457, 60, 0);
	endtask

	task automatic test_full_rate_stream(input int unsigned count);
		source_idles = 1'b0;
		sink_stalls = 1'b0;
		repeat (count) send_gps(random_gps());
	endtask

	task automatic test_back_pressure(input int unsigned count);
		source_idles = 1'b0;
		sink_stalls = 1'b1;
		repeat (count) send_gps(random_gps());
	endtask

	task automatic test_random_idling(input int unsigned count);
		source_idles = 1'b1;
		sink_stalls = 1'b1;
		repeat (count) send_gps(random_gps());
		source_idles = 1'b0;
		repeat (count / 4) send_gps(random_gps());
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_calendar_edges();
		test_full_rate_stream(150);
		test_back_pressure(200);
		test_random_idling(480);
		gps_valid <= 1'b0;
		while (expected_dates.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
